/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the NEC frame decoder. Compiled out when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check prop at every rising edge, skipped while reset is asserted.
`define NEC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nec decoder assertion failed");

// Check prop at every rising edge, reset included.
`define NEC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nec decoder assertion failed");

`else

`define NEC_ASSERT(label, clk, rst_n, prop)
`define NEC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/core/nec_pkg.sv */
// ----------------------------------------------------------------------------
// nec_pkg
// Types, constants and window helpers shared by the NEC frame decoder.
// ----------------------------------------------------------------------------
package nec_pkg;

    localparam int DURATION_BITS  = 15;
    localparam int FRAME_SYMBOLS  = 34;
    localparam int COUNT_BITS     = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int WORD_BITS      = 16;
    localparam int BYTE_BITS      = 8;

    typedef logic [DURATION_BITS-1:0] t_dur;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [WORD_BITS-1:0]     t_word;
    typedef logic [BYTE_BITS-1:0]     t_byte;

    localparam t_count COUNT_MAX     = '1;
    localparam t_count COUNT_FRAME   = t_count'(FRAME_SYMBOLS);
    localparam t_count LAST_ADDR_SYM = t_count'(WORD_BITS);
    localparam t_count LAST_DATA_SYM = t_count'(2 * WORD_BITS);

    localparam t_dur DEF_MARGIN       = t_dur'(200);
    localparam t_dur DEF_LEADER_MARK  = t_dur'(9000);
    localparam t_dur DEF_LEADER_SPACE = t_dur'(4500);
    localparam t_dur DEF_ZERO_MARK    = t_dur'(560);
    localparam t_dur DEF_ZERO_SPACE   = t_dur'(560);
    localparam t_dur DEF_ONE_MARK     = t_dur'(560);
    localparam t_dur DEF_ONE_SPACE    = t_dur'(1690);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MARGIN       = 3'd0,
        REG_LEADER_MARK  = 3'd1,
        REG_LEADER_SPACE = 3'd2,
        REG_ZERO_MARK    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_ONE_MARK     = 3'd5,
        REG_ONE_SPACE    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_LEADER = 2'd1,
        FAULT_BIT    = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_COUNT  = 3'd1,
        ST_LEADER = 3'd2,
        ST_BIT    = 3'd3,
        ST_CHECK  = 3'd4
    } t_status;

    typedef struct packed {
        t_dur mark_duration;
        t_dur space_duration;
        logic end_of_capture;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_byte   address_byte;
        t_byte   command_byte;
    } t_out_item;

    // Open interval (lo, hi); en low when the margin exceeds the nominal.
    typedef struct packed {
        logic                   en;
        t_dur                   lo;
        logic [DURATION_BITS:0] hi;
    } t_window;

    typedef struct packed {
        t_window leader_mark;
        t_window leader_space;
        t_window zero_mark;
        t_window zero_space;
        t_window one_mark;
        t_window one_space;
    } t_bounds;

    typedef struct packed {
        logic leader_ok;
        logic one_ok;
        logic zero_ok;
    } t_sym_class;

    function automatic t_window make_window(t_dur nom, t_dur margin);
        t_window w;
        w.en = (margin <= nom);
        w.lo = nom - margin;
        w.hi = {1'b0, nom} + {1'b0, margin};
        return w;
    endfunction

    function automatic logic in_window(t_dur d, t_window w);
        return w.en && (d > w.lo) && ({1'b0, d} < w.hi);
    endfunction

endpackage

/* rtl/core/nec_cfg_regs.sv */
// ----------------------------------------------------------------------------
// nec_cfg_regs
// Timing registers and the acceptance windows derived from them.
// ----------------------------------------------------------------------------
module nec_cfg_regs
    import nec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  t_dur                      i_cfg_data,
    output t_bounds                   o_bounds
);

    t_dur r_margin;
    t_dur r_leader_mark;
    t_dur r_leader_space;
    t_dur r_zero_mark;
    t_dur r_zero_space;
    t_dur r_one_mark;
    t_dur r_one_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin       <= DEF_MARGIN;
            r_leader_mark  <= DEF_LEADER_MARK;
            r_leader_space <= DEF_LEADER_SPACE;
            r_zero_mark    <= DEF_ZERO_MARK;
            r_zero_space   <= DEF_ZERO_SPACE;
            r_one_mark     <= DEF_ONE_MARK;
            r_one_space    <= DEF_ONE_SPACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MARGIN:       r_margin       <= i_cfg_data;
                REG_LEADER_MARK:  r_leader_mark  <= i_cfg_data;
                REG_LEADER_SPACE: r_leader_space <= i_cfg_data;
                REG_ZERO_MARK:    r_zero_mark    <= i_cfg_data;
                REG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                REG_ONE_MARK:     r_one_mark     <= i_cfg_data;
                REG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                default: begin
                    // drop writes past the last register
                end
            endcase
        end
    end

    always_comb begin
        o_bounds.leader_mark  = make_window(r_leader_mark,  r_margin);
        o_bounds.leader_space = make_window(r_leader_space, r_margin);
        o_bounds.zero_mark    = make_window(r_zero_mark,    r_margin);
        o_bounds.zero_space   = make_window(r_zero_space,   r_margin);
        o_bounds.one_mark     = make_window(r_one_mark,     r_margin);
        o_bounds.one_space    = make_window(r_one_space,    r_margin);
    end

endmodule

/* rtl/core/nec_sym_class.sv */
// ----------------------------------------------------------------------------
// nec_sym_class
// Window compares that classify one symbol as leader, one or zero.
// ----------------------------------------------------------------------------
module nec_sym_class
    import nec_pkg::*;
(
    input  t_in_item   i_item,
    input  t_bounds    i_bounds,
    output t_sym_class o_class
);

    always_comb begin
        o_class.leader_ok = in_window(i_item.mark_duration,  i_bounds.leader_mark)
                         && in_window(i_item.space_duration, i_bounds.leader_space);
        o_class.one_ok    = in_window(i_item.mark_duration,  i_bounds.one_mark)
                         && in_window(i_item.space_duration, i_bounds.one_space);
        o_class.zero_ok   = in_window(i_item.mark_duration,  i_bounds.zero_mark)
                         && in_window(i_item.space_duration, i_bounds.zero_space);
    end

endmodule

/* rtl/core/nec_frame_acc.sv */
// ----------------------------------------------------------------------------
// nec_frame_acc
// Frame state (symbol count, address and command shifters, first fault)
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nec_frame_acc
    import nec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_in_item   i_item,
    input  t_sym_class i_class,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    t_count    r_count;
    t_word     r_addr;
    t_word     r_cmd;
    t_fault    r_fault;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_count    n_count;
    t_word     n_addr;
    t_word     n_cmd;
    t_fault    n_fault;
    t_status   n_status;
    t_out_item n_out_data;
    logic      sym_bit;

    // A symbol that closes a capture needs a free result register.
    assign o_take = i_item_valid
                 && (!i_item.end_of_capture || !r_out_valid || i_out_ready);

    always_comb begin
        n_count = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + t_count'(1);
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_fault = r_fault;
        sym_bit = i_class.one_ok;

        if (r_count == '0) begin
            if (!i_class.leader_ok && r_fault == FAULT_NONE) begin
                n_fault = FAULT_LEADER;
            end
        end else if (r_count <= LAST_DATA_SYM) begin
            if (!i_class.one_ok && !i_class.zero_ok && r_fault == FAULT_NONE) begin
                n_fault = FAULT_BIT;
            end
            // shift in from the top, least significant bit first on the air
            if (r_count <= LAST_ADDR_SYM) begin
                n_addr = {sym_bit, r_addr[WORD_BITS-1:1]};
            end else begin
                n_cmd = {sym_bit, r_cmd[WORD_BITS-1:1]};
            end
        end

        if (n_count != COUNT_FRAME) begin
            n_status = ST_COUNT;
        end else if (n_fault == FAULT_LEADER) begin
            n_status = ST_LEADER;
        end else if (n_fault == FAULT_BIT) begin
            n_status = ST_BIT;
        end else if (n_addr[WORD_BITS-1:BYTE_BITS] != ~n_addr[BYTE_BITS-1:0]
                  || n_cmd[WORD_BITS-1:BYTE_BITS] != ~n_cmd[BYTE_BITS-1:0]) begin
            n_status = ST_CHECK;
        end else begin
            n_status = ST_OK;
        end

        n_out_data.status       = n_status;
        n_out_data.address_byte = (n_status == ST_OK) ? n_addr[WORD_BITS-1:BYTE_BITS] : '0;
        n_out_data.command_byte = (n_status == ST_OK) ? n_cmd[WORD_BITS-1:BYTE_BITS] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
            r_cmd   <= '0;
            r_fault <= FAULT_NONE;
        end else if (o_take) begin
            if (i_item.end_of_capture) begin
                r_count <= '0;
                r_addr  <= '0;
                r_cmd   <= '0;
                r_fault <= FAULT_NONE;
            end else begin
                r_count <= n_count;
                r_addr  <= n_addr;
                r_cmd   <= n_cmd;
                r_fault <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.end_of_capture) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.end_of_capture) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `NEC_ASSERT(a_clear_after_last, i_clk, i_rst_n, o_take && i_item.end_of_capture |=> r_count == '0 && r_fault == FAULT_NONE)
    `NEC_ASSERT(a_fresh_frame_clean, i_clk, i_rst_n, r_count == '0 |-> r_fault == FAULT_NONE)
    `NEC_ASSERT(a_bit_fault_after_leader, i_clk, i_rst_n, r_fault == FAULT_BIT |-> r_count >= t_count'(2))
    `NEC_ASSERT(a_failed_bytes_zero, i_clk, i_rst_n, r_out_valid && r_out_data.status != ST_OK |-> r_out_data.address_byte == '0 && r_out_data.command_byte == '0)
    `NEC_ASSERT(a_no_take_when_full, i_clk, i_rst_n, r_out_valid && !i_out_ready && i_item_valid && i_item.end_of_capture |-> !o_take)

endmodule

/* rtl/core/nec_ir_frame_decoder.sv */
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder: captured mark/space symbols in, one status
// result with address and command bytes out per capture.
// ----------------------------------------------------------------------------
// Usage:
//   Symbols enter on the i_in_* valid/ready channel, one mark duration,
//   space duration and last-of-capture flag per transfer. Only the symbol
//   that closes a capture produces a result on the o_out_* channel.
//   Timing registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while no capture is in flight; writes past the last
//   register are dropped.
//   Path: a symbol transferred on the input channel sits in the input
//   register, is classified and folded into the frame state from there,
//   and the symbol that closes a capture also loads the result register,
//   which drives o_out_valid.
//   Throughput: one symbol per cycle unless a closing symbol waits; the
//   window compares and shift update fit between input and result registers.
//   Stall: the result register holds until o_out_valid meets i_out_ready.
//   Symbols that close no capture keep flowing; a closing symbol waits in
//   the input register, and o_in_ready falls only when that register is
//   held as well.
//   Reset: timing registers return to their defaults, the frame state and
//   both valid flags clear; no result is pending after reset.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
    import nec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  t_dur                      i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_item                  i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out_data
);

    logic       r_in_valid;
    t_in_item   r_in_data;
    t_bounds    bounds;
    t_sym_class sym_class;
    logic       take;

    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    nec_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bounds    (bounds)
    );

    nec_sym_class u_sym_class (
        .i_item   (r_in_data),
        .i_bounds (bounds),
        .o_class  (sym_class)
    );

    nec_frame_acc u_frame_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_data),
        .i_class      (sym_class),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

/* dv/tb_nec_ir_frame_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder
// Self-checking bench for the NEC frame decoder. Captures are built from the
// current timing registers and sent as symbol transfers. A local decoder model
// predicts each closing result, and the results are compared in order. Runs
// directed frames, capture lengths, timing extremes, output back-pressure and
// random traffic under several idle patterns.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_decoder;
    import nec_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 280;
    localparam int HOLD_CYCLES   = 400;
    localparam int NO_FAULT      = -1;
    localparam int LONG_CAPTURE  = 98;
    localparam t_dur DUR_MAX     = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    t_dur                      i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    t_in_item                  i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    t_out_item                 o_out_data;

    // decoder model state
    t_dur      timing_reg [7];
    t_count    sym_count   = '0;
    t_word     addr_word   = '0;
    t_word     cmd_word    = '0;
    t_fault    first_fault = FAULT_NONE;
    t_out_item pending_results [$];

    int err_count     = 0;
    int sent_items    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    nec_ir_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold off the result channel while a long stall is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with none expected: status %0d", o_out_data.status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    err_count++;
                end
                if (o_out_data.address_byte !== want.address_byte) begin
                    $error("address_byte: expected %0h, got %0h",
                           want.address_byte, o_out_data.address_byte);
                    err_count++;
                end
                if (o_out_data.command_byte !== want.command_byte) begin
                    $error("command_byte: expected %0h, got %0h",
                           want.command_byte, o_out_data.command_byte);
                    err_count++;
                end
            end
        end
    end

    // Open window (nom - margin, nom + margin); empty when margin exceeds nom.
    function automatic bit window_hit(input t_dur d, input t_dur nom);
        t_dur m;
        m = timing_reg[REG_MARGIN];
        if (m > nom)
            return 1'b0;
        return (int'(d) > int'(nom) - int'(m)) && (int'(d) < int'(nom) + int'(m));
    endfunction

    function automatic void decode_symbol(input t_in_item s);
        logic      bit_val;
        t_out_item r;
        if (sym_count == 0) begin
            if (!(window_hit(s.mark_duration, timing_reg[REG_LEADER_MARK]) &&
                  window_hit(s.space_duration, timing_reg[REG_LEADER_SPACE])) &&
                first_fault == FAULT_NONE)
                first_fault = FAULT_LEADER;
        end else if (sym_count <= 2 * WORD_BITS) begin
            if (window_hit(s.mark_duration, timing_reg[REG_ONE_MARK]) &&
                window_hit(s.space_duration, timing_reg[REG_ONE_SPACE])) begin
                bit_val = 1'b1;
            end else if (window_hit(s.mark_duration, timing_reg[REG_ZERO_MARK]) &&
                         window_hit(s.space_duration, timing_reg[REG_ZERO_SPACE])) begin
                bit_val = 1'b0;
            end else begin
                bit_val = 1'b0;
                if (first_fault == FAULT_NONE)
                    first_fault = FAULT_BIT;
            end
            if (sym_count <= WORD_BITS)
                addr_word = {bit_val, addr_word[WORD_BITS-1:1]};
            else
                cmd_word = {bit_val, cmd_word[WORD_BITS-1:1]};
        end
        if (sym_count != COUNT_MAX)
            sym_count++;
        if (s.end_of_capture) begin
            if (sym_count != FRAME_SYMBOLS)
                r.status = ST_COUNT;
            else if (first_fault == FAULT_LEADER)
                r.status = ST_LEADER;
            else if (first_fault == FAULT_BIT)
                r.status = ST_BIT;
            else if (addr_word[15:8] != ~addr_word[7:0] || cmd_word[15:8] != ~cmd_word[7:0])
                r.status = ST_CHECK;
            else
                r.status = ST_OK;
            r.address_byte = (r.status == ST_OK) ? addr_word[15:8] : '0;
            r.command_byte = (r.status == ST_OK) ? cmd_word[15:8] : '0;
            pending_results.push_back(r);
            sym_count   = '0;
            addr_word   = '0;
            cmd_word    = '0;
            first_fault = FAULT_NONE;
        end
    endfunction

    function automatic t_word nec_word(input t_byte lo);
        return {~lo, lo};
    endfunction

    // Random duration strictly inside the window, or anything if it is empty.
    function automatic t_dur pick_hit(input t_dur nom);
        int lo, hi;
        lo = int'(nom) - int'(timing_reg[REG_MARGIN]) + 1;
        hi = int'(nom) + int'(timing_reg[REG_MARGIN]) - 1;
        if (hi > int'(DUR_MAX))
            hi = int'(DUR_MAX);
        if (timing_reg[REG_MARGIN] > nom || lo > hi)
            return t_dur'($urandom);
        return t_dur'($urandom_range(hi, lo));
    endfunction

    // Duration on or next to a window bound.
    function automatic t_dur pick_edge(input t_dur nom);
        int v;
        v = int'(nom) + ($urandom_range(1) ? int'(timing_reg[REG_MARGIN])
                                           : -int'(timing_reg[REG_MARGIN]))
            + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        if (v > int'(DUR_MAX))
            v = int'(DUR_MAX);
        return t_dur'(v);
    endfunction

    task automatic send_symbol(input t_in_item s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        decode_symbol(s);
        sent_items++;
    endtask

    // Build a capture of n_sym symbols; bad_at gets a mark that fits no window.
    task automatic send_capture(input t_word addr, input t_word cmd, input int n_sym,
                                input int bad_at, input int fault_pct);
        t_in_item s;
        t_dur     nm, ns;
        logic     bit_val;
        for (int i = 0; i < n_sym; i++) begin
            if (i == 0) begin
                nm = timing_reg[REG_LEADER_MARK];
                ns = timing_reg[REG_LEADER_SPACE];
            end else begin
                if (i <= WORD_BITS)
                    bit_val = addr[i-1];
                else if (i <= 2 * WORD_BITS)
                    bit_val = cmd[i-WORD_BITS-1];
                else
                    bit_val = 1'($urandom_range(1));
                nm = bit_val ? timing_reg[REG_ONE_MARK] : timing_reg[REG_ZERO_MARK];
                ns = bit_val ? timing_reg[REG_ONE_SPACE] : timing_reg[REG_ZERO_SPACE];
            end
            s.mark_duration  = pick_hit(nm);
            s.space_duration = pick_hit(ns);
            if ($urandom_range(99) < fault_pct) begin
                case ($urandom_range(2))
                    0: s.mark_duration  = pick_edge(nm);
                    1: s.space_duration = pick_edge(ns);
                    default: s.mark_duration = t_dur'($urandom);
                endcase
            end
            if (i == bad_at)
                s.mark_duration = '0;
            s.end_of_capture = (i == n_sym - 1);
            send_symbol(s);
        end
    endtask

    // Close any open capture, drop valid and wait for every result to drain.
    task automatic wait_idle();
        t_in_item s;
        if (sym_count != 0) begin
            s.mark_duration  = t_dur'($urandom);
            s.space_duration = t_dur'($urandom);
            s.end_of_capture = 1'b1;
            send_symbol(s);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input t_dur val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_ONE_SPACE)
            timing_reg[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic load_timing(input t_dur m, input t_dur lm, input t_dur ls, input t_dur zm,
                               input t_dur zs, input t_dur om, input t_dur os);
        wait_idle();
        write_reg(REG_MARGIN, m);
        write_reg(REG_LEADER_MARK, lm);
        write_reg(REG_LEADER_SPACE, ls);
        write_reg(REG_ZERO_MARK, zm);
        write_reg(REG_ZERO_SPACE, zs);
        write_reg(REG_ONE_MARK, om);
        write_reg(REG_ONE_SPACE, os);
    endtask

    task automatic test_frames();
        send_capture(nec_word(8'h00), nec_word(8'hff), FRAME_SYMBOLS, NO_FAULT, 0);
        send_capture(nec_word(8'ha5), nec_word(8'h3c), FRAME_SYMBOLS, NO_FAULT, 0);
        send_capture(16'h1234, nec_word(8'h01), FRAME_SYMBOLS, NO_FAULT, 0);
        send_capture(nec_word(8'h01), 16'hffff, FRAME_SYMBOLS, NO_FAULT, 0);
        // leader fault first, later bit faults must not replace it
        send_capture(nec_word(8'h5a), nec_word(8'h81), FRAME_SYMBOLS, 0, 30);
        send_capture(nec_word(8'h5a), nec_word(8'h81), FRAME_SYMBOLS, 20, 0);
        // the symbol after the command word is not decoded
        send_capture(nec_word(8'h7e), nec_word(8'he7), FRAME_SYMBOLS, FRAME_SYMBOLS - 1, 0);
        wait_idle();
    endtask

    task automatic test_capture_length();
        send_capture(nec_word(8'h11), nec_word(8'h22), FRAME_SYMBOLS - 1, NO_FAULT, 0);
        send_capture(nec_word(8'h11), nec_word(8'h22), FRAME_SYMBOLS + 1, NO_FAULT, 0);
        send_capture(nec_word(8'h11), nec_word(8'h22), 1, NO_FAULT, 0);
        // a count that wrapped instead of saturating would land on a full frame
        send_capture(nec_word(8'h11), nec_word(8'h22), LONG_CAPTURE, NO_FAULT, 0);
        wait_idle();
    endtask

    task automatic test_timing_extremes();
        load_timing('0, DEF_LEADER_MARK, DEF_LEADER_SPACE, DEF_ZERO_MARK, DEF_ZERO_SPACE,
                    DEF_ONE_MARK, DEF_ONE_SPACE);
        send_capture(nec_word(8'h33), nec_word(8'hcc), FRAME_SYMBOLS, NO_FAULT, 0);
        load_timing(DUR_MAX, DEF_LEADER_MARK, DEF_LEADER_SPACE, DEF_ZERO_MARK, DEF_ZERO_SPACE,
                    DEF_ONE_MARK, DEF_ONE_SPACE);
        send_capture(nec_word(8'h33), nec_word(8'hcc), FRAME_SYMBOLS, NO_FAULT, 0);
        // margin wider than the bit marks and the zero space only
        load_timing(t_dur'(600), DEF_LEADER_MARK, DEF_LEADER_SPACE, DEF_ZERO_MARK,
                    DEF_ZERO_SPACE, DEF_ONE_MARK, DEF_ONE_SPACE);
        send_capture(nec_word(8'h33), nec_word(8'hcc), FRAME_SYMBOLS, NO_FAULT, 0);
        load_timing(t_dur'(1), DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, '0);
        send_capture('0, '0, FRAME_SYMBOLS, NO_FAULT, 0);
        load_timing('0, '0, '0, '0, '0, '0, '0);
        send_capture(nec_word(8'h33), nec_word(8'hcc), FRAME_SYMBOLS, NO_FAULT, 0);
        load_timing(DEF_MARGIN, DEF_LEADER_MARK, DEF_LEADER_SPACE, DEF_ZERO_MARK,
                    DEF_ZERO_SPACE, DEF_ONE_MARK, DEF_ONE_SPACE);
        // out-of-range index must leave every register alone
        write_reg(REG_SPARE, '0);
        send_capture(nec_word(8'h96), nec_word(8'h69), FRAME_SYMBOLS, NO_FAULT, 0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_left <= HOLD_CYCLES;
        repeat (24)
            send_capture(nec_word(t_byte'($urandom)), nec_word(t_byte'($urandom)), 1,
                         NO_FAULT, 0);
        send_capture(nec_word(t_byte'($urandom)), nec_word(t_byte'($urandom)),
                     FRAME_SYMBOLS, NO_FAULT, 0);
        wait_idle();
    endtask

    task automatic test_random(input int n_items);
        int       first;
        int       pick;
        int       len;
        t_in_item s;
        first = sent_items;
        while (sent_items - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_capture(nec_word(t_byte'($urandom)), nec_word(t_byte'($urandom)),
                             FRAME_SYMBOLS, NO_FAULT, 0);
            end else if (pick < 70) begin
                send_capture(nec_word(t_byte'($urandom)), nec_word(t_byte'($urandom)),
                             FRAME_SYMBOLS, $urandom_range(FRAME_SYMBOLS - 1), 3);
            end else if (pick < 78) begin
                send_capture(t_word'($urandom), t_word'($urandom), FRAME_SYMBOLS, NO_FAULT, 0);
            end else if (pick < 88) begin
                case ($urandom_range(3))
                    0: len = FRAME_SYMBOLS - 1;
                    1: len = FRAME_SYMBOLS + 1;
                    default: len = $urandom_range(70, 1);
                endcase
                send_capture(nec_word(t_byte'($urandom)), nec_word(t_byte'($urandom)), len,
                             NO_FAULT, 2);
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    s.mark_duration  = t_dur'($urandom);
                    s.space_duration = t_dur'($urandom);
                    s.end_of_capture = 1'($urandom_range(1));
                    send_symbol(s);
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        timing_reg = '{DEF_MARGIN, DEF_LEADER_MARK, DEF_LEADER_SPACE, DEF_ZERO_MARK,
                       DEF_ZERO_SPACE, DEF_ONE_MARK, DEF_ONE_SPACE};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 59;
        test_frames();
        test_capture_length();
        test_timing_extremes();
        test_random(PHASE_ITEMS);

        send_idle_pct = 59;
        recv_idle_pct = 11;
        test_backpressure();
        load_timing(t_dur'($urandom_range(400, 50)), t_dur'($urandom_range(32000, 300)),
                    t_dur'($urandom_range(32000, 300)), t_dur'($urandom_range(32000, 300)),
                    t_dur'($urandom_range(32000, 300)), t_dur'($urandom_range(32000, 300)),
                    t_dur'($urandom_range(32000, 300)));
        test_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_timing(t_dur'($urandom_range(8, 1)), t_dur'($urandom_range(32767, 16)),
                    t_dur'($urandom_range(32767, 16)), t_dur'($urandom_range(32767, 16)),
                    t_dur'($urandom_range(32767, 16)), t_dur'($urandom_range(32767, 16)),
                    t_dur'($urandom_range(32767, 16)));
        test_random(PHASE_ITEMS);

        wait_idle();
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* nec_ir_frame_decoder.f */
+incdir+rtl/core
rtl/core/nec_pkg.sv
rtl/core/nec_cfg_regs.sv
rtl/core/nec_sym_class.sv
rtl/core/nec_frame_acc.sv
rtl/core/nec_ir_frame_decoder.sv
dv/tb_nec_ir_frame_decoder.sv
